// ===== hdl/url_and_entity_decoder_defines.svh =====
// assertion macros for the url and entity decoder
`ifndef URL_AND_ENTITY_DECODER_DEFINES_SVH
`define URL_AND_ENTITY_DECODER_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define UAED_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define UAED_ASSERT_NEVER(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(prop)) else $error(msg);
`else
`define UAED_ASSERT(lbl, prop, msg)
`define UAED_ASSERT_NEVER(lbl, prop, msg)
`endif
`endif

// ===== hdl/uaed_pkg.sv =====
`default_nettype none
package uaed_pkg;

  localparam int unsigned UaedQueueDepth = 4;
  localparam int unsigned SymSlots = 4;
  localparam int unsigned NumJobs = SymSlots + 1;

  localparam logic [7:0] ChPct   = 8'h25;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChAmp   = 8'h26;
  localparam logic [7:0] ChSemi  = 8'h3B;
  localparam logic [7:0] CtlLimit = 8'd32;
  localparam logic [7:0] CtlKeep  = 8'd1;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       string_end;
  } uaed_in_t;

  typedef struct packed {
    logic [7:0] byte_out;
    logic       run_last;
    logic       string_done;
  } uaed_out_t;

  // bytes handed from the percent stage to the entity stage for one transaction
  typedef struct packed {
    logic [SymSlots-1:0][7:0] sym;
    logic [2:0]               cnt;
    logic                     last;
  } uaed_sym_t;

endpackage
`default_nettype wire

// ===== hdl/uaed_front.sv =====
`default_nettype none
module uaed_front import uaed_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  uaed_in_t  in_data_i,
  output logic      in_stall_o,
  input  logic      q_full_i,
  output logic      q_push_o,
  output uaed_sym_t q_data_o
);

  typedef enum logic [1:0] {PhIdle, PhPct, PhDigit} phase_e;

  phase_e     phase_q, phase_d;
  logic [7:0] held_q, held_d;

  function automatic logic is_hex(input logic [7:0] c);
    return c inside {[8'h30:8'h39], [8'h61:8'h66], [8'h41:8'h46]};
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] r;
    if (c inside {[8'h30:8'h39]}) r = c - 8'h30;
    else if (c inside {[8'h61:8'h66]}) r = c - 8'h57;
    else if (c inside {[8'h41:8'h46]}) r = c - 8'h37;
    else r = 8'h00;
    return r[3:0];
  endfunction

  always_comb begin
    logic [7:0]                b;
    logic [7:0]                v;
    logic                      plain;
    logic [2:0]                n;
    logic [SymSlots-1:0][7:0]  syms;
    phase_d = phase_q;
    held_d  = held_q;
    syms    = '0;
    n       = 3'd0;
    plain   = 1'b0;
    v       = 8'h00;
    b       = in_data_i.byte_in;
    if (b != 8'h00) begin
      case (phase_q)
        PhIdle: begin
          plain = 1'b1;
        end
        PhPct: begin
          if (is_hex(b)) begin
            held_d  = b;
            phase_d = PhDigit;
          end else begin
            phase_d = PhIdle;
            syms[n[1:0]] = ChPct;
            n = n + 3'd1;
            plain = 1'b1;
          end
        end
        PhDigit: begin
          phase_d = PhIdle;
          if (is_hex(held_q) && is_hex(b)) begin
            v = {hex_val(held_q), hex_val(b)};
            if (v != CtlKeep && v < CtlLimit) v = ChSpace;
            syms[n[1:0]] = v;
            n = n + 3'd1;
          end else begin
            syms[n[1:0]] = ChPct;
            n = n + 3'd1;
            syms[n[1:0]] = held_q;
            n = n + 3'd1;
            plain = 1'b1;
          end
        end
        default: begin
          phase_d = PhIdle;
          plain   = 1'b1;
        end
      endcase
      if (plain) begin
        if (b == ChPct) begin
          phase_d = PhPct;
        end else begin
          syms[n[1:0]] = (b == ChPlus) ? ChSpace : b;
          n = n + 3'd1;
        end
      end
    end
    if (in_data_i.string_end) begin
      if (phase_d == PhPct) begin
        syms[n[1:0]] = ChPct;
        n = n + 3'd1;
      end else if (phase_d == PhDigit) begin
        syms[n[1:0]] = ChPct;
        n = n + 3'd1;
        syms[n[1:0]] = held_d;
        n = n + 3'd1;
      end
      phase_d = PhIdle;
      held_d  = 8'h00;
    end
    q_data_o.sym  = syms;
    q_data_o.cnt  = n;
    q_data_o.last = in_data_i.string_end;
  end

  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i & ~q_full_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      held_q  <= 8'h00;
    end else if (q_push_o) begin
      phase_q <= phase_d;
      held_q  <= held_d;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/uaed_fifo.sv =====
`default_nettype none
`include "url_and_entity_decoder_defines.svh"
module uaed_fifo import uaed_pkg::*; #(
  parameter int unsigned Depth = UaedQueueDepth
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  uaed_sym_t data_i,
  output logic      full_o,
  output logic      valid_o,
  output uaed_sym_t data_o,
  input  logic      pop_i
);

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);

  uaed_sym_t      mem_q [Depth];
  logic [AW-1:0]  wr_q, rd_q;
  logic [CW-1:0]  cnt_q;

  function automatic logic [AW-1:0] next_ptr(input logic [AW-1:0] p);
    return (p == AW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full_o  = (cnt_q == CW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= next_ptr(wr_q);
      if (pop_i) rd_q <= next_ptr(rd_q);
      if (push_i && !pop_i) cnt_q <= cnt_q + 1'b1;
      else if (!push_i && pop_i) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

  `UAED_ASSERT(a_cnt_bound, cnt_q <= CW'(Depth), "queue count beyond depth")
  `UAED_ASSERT_NEVER(a_pop_empty, pop_i && cnt_q == '0, "pop from empty queue")
  `UAED_ASSERT_NEVER(a_push_full, push_i && full_o, "push into full queue")

endmodule
`default_nettype wire

// ===== hdl/uaed_back.sv =====
`default_nettype none
`include "url_and_entity_decoder_defines.svh"
module uaed_back import uaed_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      q_valid_i,
  input  uaed_sym_t q_data_i,
  output logic      q_pop_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output uaed_out_t out_data_o
);

  typedef enum logic [3:0] {
    EnIdle, EnAnd, EnA, EnAp, EnApo, EnApos, EnAm, EnAmp,
    EnG, EnGt, EnL, EnLt, EnQ, EnQu, EnQuo, EnQuot
  } ent_e;

  // one flush of a pending prefix followed by an optional byte
  typedef struct packed {
    ent_e       fs;
    logic [7:0] tb;
    logic       tv;
  } job_t;

  function automatic ent_e ent_edge(input ent_e s, input logic [7:0] c);
    ent_e r;
    r = EnIdle;
    case (s)
      EnAnd: begin
        if (c == "a") r = EnA;
        else if (c == "g") r = EnG;
        else if (c == "l") r = EnL;
        else if (c == "q") r = EnQ;
      end
      EnA:   begin
        if (c == "p") r = EnAp;
        else if (c == "m") r = EnAm;
      end
      EnAp:  if (c == "o") r = EnApo;
      EnApo: if (c == "s") r = EnApos;
      EnAm:  if (c == "p") r = EnAmp;
      EnG:   if (c == "t") r = EnGt;
      EnL:   if (c == "t") r = EnLt;
      EnQ:   if (c == "u") r = EnQu;
      EnQu:  if (c == "o") r = EnQuo;
      EnQuo: if (c == "t") r = EnQuot;
      default: r = EnIdle;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] ent_result(input ent_e s);
    logic [7:0] r;
    case (s)
      EnApos:  r = 8'h27;
      EnAmp:   r = 8'h26;
      EnGt:    r = 8'h3E;
      EnLt:    r = 8'h3C;
      EnQuot:  r = 8'h22;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [2:0] pre_len(input ent_e s);
    logic [2:0] r;
    case (s)
      EnA, EnG, EnL, EnQ:            r = 3'd1;
      EnAp, EnAm, EnGt, EnLt, EnQu:  r = 3'd2;
      EnApo, EnAmp, EnQuo:           r = 3'd3;
      EnApos, EnQuot:                r = 3'd4;
      default:                       r = 3'd0;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] pre_char(input ent_e s, input logic [1:0] i);
    logic [7:0] r;
    case (s)
      EnA, EnAp, EnApo, EnApos: begin
        case (i)
          2'd0:    r = "a";
          2'd1:    r = "p";
          2'd2:    r = "o";
          default: r = "s";
        endcase
      end
      EnAm, EnAmp: begin
        case (i)
          2'd0:    r = "a";
          2'd1:    r = "m";
          default: r = "p";
        endcase
      end
      EnG, EnGt: r = (i == 2'd0) ? "g" : "t";
      EnL, EnLt: r = (i == 2'd0) ? "l" : "t";
      EnQ, EnQu, EnQuo, EnQuot: begin
        case (i)
          2'd0:    r = "q";
          2'd1:    r = "u";
          2'd2:    r = "o";
          default: r = "t";
        endcase
      end
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  job_t [NumJobs-1:0] job_q, job_d;
  logic [NumJobs-1:0] rem_q, rem_d;
  logic [2:0]         pos_q;
  logic               end_q;
  ent_e               st_q, st_d;
  logic               out_valid_q;
  uaed_out_t          out_data_q;

  logic [2:0]         cj;
  job_t               cur;
  logic               has;
  logic [2:0]         plen;
  logic [2:0]         jlen;
  logic [7:0]         ob;
  logic               job_last;
  logic               item_last;
  logic               emit;
  logic               load;

  // entity matching over the symbols of the transaction at the queue head
  always_comb begin
    ent_e       s;
    ent_e       e;
    logic [7:0] c;
    logic [7:0] r;
    s     = st_q;
    job_d = '0;
    for (int i = 0; i < SymSlots; i++) begin
      c = q_data_i.sym[i];
      e = ent_edge(s, c);
      r = ent_result(s);
      if (3'(i) < q_data_i.cnt) begin
        if (s != EnIdle) begin
          if (c == ChSemi && r != 8'h00) begin
            job_d[i].tb = r;
            job_d[i].tv = 1'b1;
            s = EnIdle;
          end else if (e != EnIdle) begin
            s = e;
          end else begin
            job_d[i].fs = s;
            if (c == ChAmp) begin
              s = EnAnd;
            end else begin
              job_d[i].tb = c;
              job_d[i].tv = 1'b1;
              s = EnIdle;
            end
          end
        end else if (c == ChAmp) begin
          s = EnAnd;
        end else begin
          job_d[i].tb = c;
          job_d[i].tv = 1'b1;
        end
      end
    end
    if (q_data_i.last) begin
      job_d[NumJobs-1].fs = s;
      s = EnIdle;
    end
    st_d = s;
    for (int i = 0; i < NumJobs; i++) begin
      rem_d[i] = (job_d[i].fs != EnIdle) || job_d[i].tv;
    end
  end

  // byte selection for the current job
  always_comb begin
    cj = 3'd0;
    for (int i = NumJobs - 1; i >= 0; i--) begin
      if (rem_q[i]) cj = 3'(i);
    end
    cur  = job_q[cj];
    has  = (cur.fs != EnIdle);
    plen = pre_len(cur.fs);
    jlen = (has ? plen + 3'd1 : 3'd0) + {2'b00, cur.tv};
    if (has && pos_q == 3'd0) ob = ChAmp;
    else if (has && pos_q <= plen) ob = pre_char(cur.fs, 2'(pos_q - 3'd1));
    else ob = cur.tb;
    job_last  = (pos_q == jlen - 3'd1);
    item_last = job_last && ((rem_q & ~(NumJobs'(1) << cj)) == '0);
    emit      = (rem_q != '0) && (!out_valid_q || !out_stall_i);
    load      = q_valid_i && ((rem_q == '0) || (emit && item_last));
  end

  assign q_pop_o     = load;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
      rem_q       <= '0;
      pos_q       <= 3'd0;
      end_q       <= 1'b0;
      st_q        <= EnIdle;
    end else begin
      if (emit) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
      if (emit) begin
        out_data_q.byte_out    <= ob;
        out_data_q.run_last    <= item_last;
        out_data_q.string_done <= item_last && end_q;
      end
      if (load) begin
        rem_q <= rem_d;
        pos_q <= 3'd0;
        end_q <= q_data_i.last;
        st_q  <= st_d;
      end else if (emit) begin
        if (job_last) begin
          rem_q[cj] <= 1'b0;
          pos_q     <= 3'd0;
        end else begin
          pos_q <= pos_q + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) job_q <= job_d;
  end

  `UAED_ASSERT(a_done_last,
    out_valid_o |-> (!out_data_o.string_done || out_data_o.run_last),
    "done without last")
  `UAED_ASSERT(a_load_free, q_pop_o |-> (rem_q == '0 || item_last), "load over pending bytes")

endmodule
`default_nettype wire

// ===== hdl/url_and_entity_decoder.sv =====
// path: a decoded byte passes the queue, the job register and the output register before out_valid_o shows it
// throughput: one input transaction per cycle while each yields at most one byte and out_stall_i is low
// a transaction yielding k bytes holds the emitter until all k are sent; the queue absorbs bursts
// reset: asynchronous active low, clears escape and entity state, queue and output register
`default_nettype none
module url_and_entity_decoder import uaed_pkg::*; #(
  parameter int unsigned QueueDepth = UaedQueueDepth
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  uaed_in_t  in_data_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output uaed_out_t out_data_o
);

  logic      q_full;
  logic      q_push;
  logic      q_valid;
  logic      q_pop;
  uaed_sym_t q_wdata;
  uaed_sym_t q_rdata;

  uaed_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .in_stall_o (in_stall_o),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_data_o   (q_wdata)
  );

  uaed_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .valid_o (q_valid),
    .data_o  (q_rdata),
    .pop_i   (q_pop)
  );

  uaed_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_data_i    (q_rdata),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
`default_nettype wire
